/* rtl/hjc_pkg.sv */
// ----------------------------------------------------------------------------
// hjc_pkg
// types, register indexes and constants shared by the handwheel jog blocks
// ----------------------------------------------------------------------------
`default_nettype none

package hjc_pkg;

  typedef struct packed {
    logic       func;
    logic       enc_a;
    logic       enc_b;
    logic [3:0] axis_switches;
    logic [2:0] speed_switches;
    logic       planner_idle;
    logic [3:0] motor_count;
  } in_t;

  typedef struct packed {
    logic [2:0]  axis_sel;
    logic [7:0]  speed_mult;
    logic        pilot_on;
    logic        move_granted;
    logic        step_dir;
    logic [22:0] step_total;
    logic [15:0] step_gap;
  } out_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MID = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP_GAP = 3'd4;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SERVICE = 1'b1;

  localparam logic [2:0] NO_AXIS = 3'd4;
  localparam logic signed [15:0] COUNT_LIMIT = 16'sd32767;
  localparam logic [9:0] GAP_NUMERATOR = 10'd1000;
  localparam int ALU_W = 24;
  localparam int MUL_STEPS = 8;

  // quadrature transition table, index {previous ab, current ab}
  function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* rtl/hjc_alu.sv */
// ----------------------------------------------------------------------------
// hjc_alu
// shared add / subtract unit used for the multiply, divide and compare steps
// ----------------------------------------------------------------------------
`default_nettype none

module hjc_alu (
  input  wire logic [hjc_pkg::ALU_W-1:0] a,
  input  wire logic [hjc_pkg::ALU_W-1:0] b,
  input  wire logic                      sub,
  output logic      [hjc_pkg::ALU_W-1:0] sum,
  output logic                           ge
);
  import hjc_pkg::*;

  logic [ALU_W:0] wide;

  always_comb begin
    wide = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{ALU_W{1'b0}}, sub};
    sum = wide[ALU_W-1:0];
    ge = wide[ALU_W];
  end

endmodule

`default_nettype wire

/* rtl/hjc_quad.sv */
// ----------------------------------------------------------------------------
// hjc_quad
// quadrature decoder and saturating pulse count, cleared when read
// ----------------------------------------------------------------------------
`default_nettype none

module hjc_quad (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               enc_en,
  input  wire logic               tick,
  input  wire logic               enc_a,
  input  wire logic               enc_b,
  input  wire logic               clear,
  output logic signed [15:0]      count
);
  import hjc_pkg::*;

  logic [1:0]        last_ab;
  logic [1:0]        cur_ab;
  logic signed [1:0] delta;

  assign cur_ab = {enc_b, enc_a};
  assign delta = quad_delta({last_ab, cur_ab});

  always_ff @(posedge clk) begin
    if (rst) begin
      last_ab <= 2'd0;
      count <= 16'sd0;
    end else if (clear) begin
      count <= 16'sd0;
    end else if (tick && enc_en) begin
      last_ab <= cur_ab;
      if (delta == 2'sd1 && count != COUNT_LIMIT) begin
        count <= count + 16'sd1;
      end else if (delta == -2'sd1 && count != -COUNT_LIMIT) begin
        count <= count - 16'sd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/handwheel_jog_controller.sv */
// ----------------------------------------------------------------------------
// handwheel_jog_controller
// An encoder tick item leaves in_ready high and gives no result. A granted
// service item with a nonzero total passes through these steps, with in_ready
// low after the first: one to select axis and multiplier and read the count,
// eight shift-add steps for the step total, ten restoring divide steps for
// 1000 / total, one compare against the minimum gap, and one to load the output
// register. The multiply, divide and compare steps run through one shared
// 24-bit add/subtract unit. A granted event with a zero total skips the divide
// and compare; an ungranted event goes straight to the output register. While
// a result waits for out_ready the block holds in its last step, so in_ready
// stays low until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module handwheel_jog_controller (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire hjc_pkg::in_t                     in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output hjc_pkg::out_t                         out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hjc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hjc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hjc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CMP,
    ST_FINISH
  } state_t;

  state_t state;

  logic        encoder_enabled;
  logic [7:0]  speed_low_value;
  logic [7:0]  speed_mid_value;
  logic [7:0]  speed_high_value;
  logic [15:0] min_step_gap;

  logic [2:0]  cur_axis;
  logic [7:0]  cur_mult;
  logic        granted;
  logic        dir;
  logic [22:0] acc;
  logic [22:0] mcand;
  logic [7:0]  mplier;
  logic [3:0]  cnt;
  logic [9:0]  rem;
  logic [9:0]  quo;
  logic [15:0] gap;

  logic              in_acc;
  logic              tick;
  logic              svc;
  logic signed [15:0] count;
  logic [2:0]        sel_axis;
  logic [7:0]        next_mult;
  logic              axis_changed;
  logic signed [15:0] taken;
  logic [15:0]       taken_abs;
  logic [14:0]       steps;
  logic              grant_now;

  logic [ALU_W-1:0]  alu_a;
  logic [ALU_W-1:0]  alu_b;
  logic              alu_sub;
  logic [ALU_W-1:0]  alu_sum;
  logic              alu_ge;
  logic [10:0]       trial;
  logic [22:0]       acc_next;

  assign in_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc = in_valid && in_ready;
  assign tick = in_acc && (in_data.func == FUNC_TICK);
  assign svc = in_acc && (in_data.func == FUNC_SERVICE);

  always_comb begin
    if (in_data.axis_switches[0]) begin
      sel_axis = 3'd0;
    end else if (in_data.axis_switches[1]) begin
      sel_axis = 3'd1;
    end else if (in_data.axis_switches[2]) begin
      sel_axis = 3'd2;
    end else if (in_data.axis_switches[3]) begin
      sel_axis = 3'd3;
    end else begin
      sel_axis = NO_AXIS;
    end
    if (in_data.speed_switches[0]) begin
      next_mult = speed_low_value;
    end else if (in_data.speed_switches[1]) begin
      next_mult = speed_mid_value;
    end else if (in_data.speed_switches[2]) begin
      next_mult = speed_high_value;
    end else begin
      next_mult = 8'd0;
    end
    axis_changed = (sel_axis != cur_axis);
    taken = axis_changed ? 16'sd0 : count;
    taken_abs = taken[15] ? 16'(-taken) : 16'(taken);
    steps = taken_abs[14:0];
    grant_now = in_data.planner_idle && (sel_axis != NO_AXIS)
                && ({1'b0, sel_axis} < in_data.motor_count) && (steps != 15'd0);
  end

  hjc_quad u_quad (
    .clk    (clk),
    .rst    (rst),
    .enc_en (encoder_enabled),
    .tick   (tick),
    .enc_a  (in_data.enc_a),
    .enc_b  (in_data.enc_b),
    .clear  (svc),
    .count  (count)
  );

  assign trial = {rem, GAP_NUMERATOR[cnt]};

  always_comb begin
    alu_a = {1'b0, acc};
    alu_b = {1'b0, mcand};
    alu_sub = 1'b0;
    case (state)
      ST_MUL: begin
        alu_a = {1'b0, acc};
        alu_b = {1'b0, mcand};
        alu_sub = 1'b0;
      end
      ST_DIV: begin
        alu_a = {13'd0, trial};
        alu_b = {1'b0, acc};
        alu_sub = 1'b1;
      end
      ST_CMP: begin
        alu_a = {14'd0, quo};
        alu_b = {8'd0, min_step_gap};
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  hjc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum),
    .ge  (alu_ge)
  );

  assign acc_next = mplier[0] ? alu_sum[22:0] : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_enabled <= 1'b0;
      speed_low_value <= 8'd1;
      speed_mid_value <= 8'd10;
      speed_high_value <= 8'd100;
      min_step_gap <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENCODER_ENABLED: encoder_enabled <= cfg_data[0];
        CFG_SPEED_LOW: speed_low_value <= cfg_data[7:0];
        CFG_SPEED_MID: speed_mid_value <= cfg_data[7:0];
        CFG_SPEED_HIGH: speed_high_value <= cfg_data[7:0];
        CFG_MIN_STEP_GAP: min_step_gap <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      cur_axis <= NO_AXIS;
      cur_mult <= 8'd1;
    end else begin
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (svc) begin
            cur_axis <= sel_axis;
            cur_mult <= next_mult;
            granted <= grant_now;
            dir <= !taken[15] && (taken != 16'sd0);
            acc <= 23'd0;
            mcand <= {8'd0, steps};
            mplier <= next_mult;
            cnt <= 4'd0;
            gap <= min_step_gap;
            state <= grant_now ? ST_MUL : ST_FINISH;
          end
        end
        ST_MUL: begin
          acc <= acc_next;
          mcand <= {mcand[21:0], 1'b0};
          mplier <= {1'b0, mplier[7:1]};
          if (cnt == 4'(MUL_STEPS - 1)) begin
            rem <= 10'd0;
            quo <= 10'd0;
            cnt <= 4'd9;
            state <= (acc_next == 23'd0) ? ST_FINISH : ST_DIV;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_DIV: begin
          rem <= alu_ge ? alu_sum[9:0] : trial[9:0];
          quo <= {quo[8:0], alu_ge};
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          gap <= alu_ge ? {6'd0, quo} : min_step_gap;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data.axis_sel <= cur_axis;
            out_data.speed_mult <= cur_mult;
            out_data.pilot_on <= (cur_axis != NO_AXIS);
            out_data.move_granted <= granted;
            out_data.step_dir <= dir;
            out_data.step_total <= acc;
            out_data.step_gap <= gap;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* verif/tb_handwheel_jog_controller.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_handwheel_jog_controller
// Drives encoder ticks and service events through the valid/ready input and
// checks every jog move against a cycle-free model of the controller. Covers
// encoder enable, long one-way runs, axis and speed priority, grant rules and
// the step gap under several register settings, with random gaps on both
// sides and one long output stall.
// ----------------------------------------------------------------------------

module tb_handwheel_jog_controller;
  import hjc_pkg::*;

  localparam int QUAD_STEP [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_HI = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int RUN_TICKS = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  handwheel_jog_controller u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // controller model: registers and state
  logic enc_on = 1'b0;
  logic [7:0] mult_low = 8'd1;
  logic [7:0] mult_mid = 8'd10;
  logic [7:0] mult_high = 8'd100;
  logic [15:0] gap_floor = 16'd100;
  logic [1:0] prev_ab = 2'd0;
  int pulse_sum = 0;
  logic [2:0] held_axis = NO_AXIS;
  logic [7:0] held_mult = 8'd1;

  in_t items_to_send[$];
  out_t jog_moves_due[$];
  int items_queued = 0;
  int items_taken = 0;
  int error_count = 0;
  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;
  logic no_gaps = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  logic [1:0] gen_ab = 2'd0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_error(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    error_count++;
  endtask

  task automatic model_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_ENCODER_ENABLED: enc_on = val[0];
      CFG_SPEED_LOW: mult_low = val[7:0];
      CFG_SPEED_MID: mult_mid = val[7:0];
      CFG_SPEED_HIGH: mult_high = val[7:0];
      CFG_MIN_STEP_GAP: gap_floor = val;
      default: ;
    endcase
  endtask

  task automatic predict_jog(input in_t it);
    logic [3:0] idx;
    logic [2:0] axis_now;
    int nxt;
    int taken;
    int mag;
    int total;
    int gap;
    logic granted;
    out_t mv;
    if (it.func == FUNC_TICK) begin
      if (enc_on) begin
        idx = {prev_ab, it.enc_b, it.enc_a};
        nxt = pulse_sum + QUAD_STEP[idx];
        if (nxt > int'(COUNT_LIMIT)) nxt = int'(COUNT_LIMIT);
        if (nxt < -int'(COUNT_LIMIT)) nxt = -int'(COUNT_LIMIT);
        pulse_sum = nxt;
        prev_ab = {it.enc_b, it.enc_a};
      end
    end else begin
      if (it.axis_switches[0]) axis_now = 3'd0;
      else if (it.axis_switches[1]) axis_now = 3'd1;
      else if (it.axis_switches[2]) axis_now = 3'd2;
      else if (it.axis_switches[3]) axis_now = 3'd3;
      else axis_now = NO_AXIS;
      if (axis_now != held_axis) begin
        held_axis = axis_now;
        pulse_sum = 0;
      end
      if (it.speed_switches[0]) held_mult = mult_low;
      else if (it.speed_switches[1]) held_mult = mult_mid;
      else if (it.speed_switches[2]) held_mult = mult_high;
      else held_mult = 8'd0;
      taken = pulse_sum;
      pulse_sum = 0;
      mag = (taken < 0) ? -taken : taken;
      granted = it.planner_idle && held_axis != NO_AXIS && {1'b0, held_axis} < it.motor_count
                && mag != 0;
      total = 0;
      gap = gap_floor;
      if (granted) begin
        total = mag * held_mult;
        if (total != 0 && int'(GAP_NUMERATOR) / total > gap) gap = int'(GAP_NUMERATOR) / total;
      end
      mv.axis_sel = held_axis;
      mv.speed_mult = held_mult;
      mv.pilot_on = held_axis != NO_AXIS;
      mv.move_granted = granted;
      mv.step_dir = taken > 0;
      mv.step_total = total[22:0];
      mv.step_gap = gap[15:0];
      jog_moves_due.push_back(mv);
    end
  endtask

  task automatic check_move(input out_t got);
    out_t want;
    if (jog_moves_due.size() == 0) begin
      flag_error("result with none pending", 1, 0);
      return;
    end
    want = jog_moves_due.pop_front();
    if (got.axis_sel !== want.axis_sel) flag_error("axis_sel", got.axis_sel, want.axis_sel);
    if (got.speed_mult !== want.speed_mult)
      flag_error("speed_mult", got.speed_mult, want.speed_mult);
    if (got.pilot_on !== want.pilot_on) flag_error("pilot_on", got.pilot_on, want.pilot_on);
    if (got.move_granted !== want.move_granted)
      flag_error("move_granted", got.move_granted, want.move_granted);
    if (got.step_dir !== want.step_dir) flag_error("step_dir", got.step_dir, want.step_dir);
    if (got.step_total !== want.step_total)
      flag_error("step_total", got.step_total, want.step_total);
    if (got.step_gap !== want.step_gap) flag_error("step_gap", got.step_gap, want.step_gap);
  endtask

  // monitor
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (!rst) begin
      if (out_valid && out_ready) check_move(out_data);
      if (cfg_valid && cfg_ready) model_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        predict_jog(in_data);
        items_taken++;
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (items_to_send.size() != 0 && (no_gaps || $urandom_range(99) >= 21)) begin
        in_data <= items_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done < hold_requests) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_ready <= no_gaps || ($urandom_range(99) >= 21);
    end
  end

  function automatic logic [1:0] next_ab(input logic [1:0] ab, input bit up);
    case (ab)
      2'd0: return up ? 2'd2 : 2'd1;
      2'd1: return up ? 2'd0 : 2'd3;
      2'd2: return up ? 2'd3 : 2'd0;
      default: return up ? 2'd1 : 2'd2;
    endcase
  endfunction

  task automatic push_item(input in_t it);
    items_to_send.push_back(it);
    items_queued++;
  endtask

  task automatic push_tick(input logic [1:0] ab);
    in_t it;
    it = in_t'(15'($urandom));
    it.func = FUNC_TICK;
    it.enc_a = ab[0];
    it.enc_b = ab[1];
    gen_ab = ab;
    push_item(it);
  endtask

  task automatic push_steps(input int n, input bit up);
    repeat (n) push_tick(next_ab(gen_ab, up));
  endtask

  task automatic push_service(input logic [3:0] axes, input logic [2:0] speeds,
                              input logic idle, input logic [3:0] motors);
    in_t it;
    it = in_t'(15'($urandom));
    it.func = FUNC_SERVICE;
    it.axis_switches = axes;
    it.speed_switches = speeds;
    it.planner_idle = idle;
    it.motor_count = motors;
    push_item(it);
  endtask

  task automatic push_random(input int n, input bit short_bursts);
    int left;
    int burst;
    bit up;
    logic [3:0] home_axis;
    logic [3:0] axes;
    logic [3:0] motors;
    left = n;
    home_axis = 4'b0001 << $urandom_range(3);
    while (left > 0) begin
      if ($urandom_range(99) < 10) begin
        push_item(in_t'(15'($urandom)));
        left--;
      end else begin
        if (short_bursts) burst = $urandom_range(2);
        else if ($urandom_range(9) == 0) burst = $urandom_range(200);
        else burst = $urandom_range(12);
        up = $urandom_range(1);
        repeat (burst) begin
          if ($urandom_range(99) < 5) push_tick(2'($urandom_range(3)));
          else push_tick(next_ab(gen_ab, up));
        end
        if ($urandom_range(19) == 0) home_axis = 4'b0001 << $urandom_range(3);
        axes = ($urandom_range(9) < 8) ? home_axis : 4'($urandom_range(15));
        motors = ($urandom_range(9) < 6) ? 4'($urandom_range(15, 4)) : 4'($urandom_range(15));
        push_service(axes, 3'($urandom_range(7)), $urandom_range(99) < 85, motors);
        left -= burst + 1;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || jog_moves_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_speeds(input logic [15:0] lo, input logic [15:0] mid,
                              input logic [15:0] hi, input logic [15:0] gap);
    write_reg(CFG_SPEED_LOW, lo);
    write_reg(CFG_SPEED_MID, mid);
    write_reg(CFG_SPEED_HIGH, hi);
    write_reg(CFG_MIN_STEP_GAP, gap);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    repeat (2) @(negedge clk);

    // encoder disabled after reset
    push_tick(2'd1);
    push_tick(2'd3);
    push_service(4'b0001, 3'b001, 1'b1, 4'd4);
    push_service(4'b0001, 3'b001, 1'b1, 4'd4);
    wait_idle();
    write_reg(CFG_ENCODER_ENABLED, 16'd1);

    gen_ab = 2'd0;
    push_steps(4, 1'b0);
    push_service(4'b0001, 3'b111, 1'b1, 4'd1);
    push_steps(5, 1'b1);
    push_service(4'b1110, 3'b100, 1'b1, 4'd15);
    push_steps(2, 1'b1);
    push_tick(~gen_ab);
    push_service(4'b0010, 3'b000, 1'b1, 4'd2);
    push_steps(1, 1'b1);
    push_service(4'b0010, 3'b010, 1'b0, 4'd15);
    push_steps(1, 1'b0);
    push_service(4'b0000, 3'b100, 1'b1, 4'd15);
    push_service(4'b1000, 3'b100, 1'b1, 4'd3);
    wait_idle();

    // long runs both ways
    push_steps(RUN_TICKS, 1'b1);
    push_service(4'b1000, 3'b100, 1'b1, 4'd4);
    push_steps(RUN_TICKS, 1'b0);
    push_service(4'b1000, 3'b001, 1'b1, 4'd0);
    push_steps(RUN_TICKS, 1'b0);
    push_service(4'b1000, 3'b001, 1'b1, 4'd15);
    wait_idle();

    write_speeds(16'd255, 16'd255, 16'd255, 16'd0);
    @(posedge clk) no_gaps = 1'b1;
    push_random(300, 1'b0);
    wait_idle();
    no_gaps = 1'b0;

    write_speeds(16'd0, 16'd1, 16'd2, 16'hffff);
    write_reg(CFG_NO_REG_LO, 16'hffff);
    @(posedge clk) hold_requests++;
    push_random(300, 1'b1);
    wait_idle();

    write_reg(CFG_ENCODER_ENABLED, 16'hfffe);
    push_random(200, 1'b0);
    wait_idle();

    write_reg(CFG_ENCODER_ENABLED, 16'h0003);
    write_speeds(16'hab03, 16'h1207, 16'hffc8, 16'd5);
    push_random(300, 1'b0);
    wait_idle();

    write_speeds(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(2000)));
    write_reg(CFG_NO_REG_HI, 16'h0000);
    push_random(300, 1'b0);
    wait_idle();

    write_speeds(16'd1, 16'd10, 16'd100, 16'd100);
    push_random(200, 1'b0);
    wait_idle();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
